// ===== rtl/core/quad_lagrange_basis_eval_core_defines.svh =====
// Assertion helpers for the checker file.
`ifndef QUAD_LAGRANGE_BASIS_EVAL_CORE_DEFINES_SVH
`define QUAD_LAGRANGE_BASIS_EVAL_CORE_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define QLB_ASSERT_CLK(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset.
`define QLB_ASSERT(label, prop, msg) \
	`QLB_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// ===== rtl/core/qlb_pkg.sv =====
`timescale 1ns / 1ps

package qlb_pkg;

	localparam logic ORDER_Q1 = 1'b0;
	localparam logic ORDER_Q2 = 1'b1;

	// 1D factor selectors; linear uses FACT_0 (1-t) and FACT_1 (t)
	localparam logic [1:0] FACT_0 = 2'd0;
	localparam logic [1:0] FACT_1 = 2'd1;
	localparam logic [1:0] FACT_2 = 2'd2;

	typedef struct packed {
		logic [1:0] iu;
		logic [1:0] iv;
		logic       bad;
	} qlb_node_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} qlb_adv_t;

	function automatic qlb_node_t node_decode(input logic order, input logic [3:0] node);
		qlb_node_t r;
		r.iu  = FACT_0;
		r.iv  = FACT_0;
		r.bad = 1'b0;
		if (order == ORDER_Q1) begin
			case (node)
				4'd0: begin r.iu = FACT_0; r.iv = FACT_0; end
				4'd1: begin r.iu = FACT_1; r.iv = FACT_0; end
				4'd2: begin r.iu = FACT_1; r.iv = FACT_1; end
				4'd3: begin r.iu = FACT_0; r.iv = FACT_1; end
				default: r.bad = 1'b1;
			endcase
		end else begin
			case (node)
				4'd0: begin r.iu = FACT_0; r.iv = FACT_0; end
				4'd1: begin r.iu = FACT_2; r.iv = FACT_0; end
				4'd2: begin r.iu = FACT_2; r.iv = FACT_2; end
				4'd3: begin r.iu = FACT_0; r.iv = FACT_2; end
				4'd4: begin r.iu = FACT_1; r.iv = FACT_0; end
				4'd5: begin r.iu = FACT_2; r.iv = FACT_1; end
				4'd6: begin r.iu = FACT_1; r.iv = FACT_2; end
				4'd7: begin r.iu = FACT_0; r.iv = FACT_1; end
				4'd8: begin r.iu = FACT_1; r.iv = FACT_1; end
				default: r.bad = 1'b1;
			endcase
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/qlb_factor.sv =====
`timescale 1ns / 1ps

// 1D Lagrange factor and its derivative, two register stages.
module qlb_factor #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  qlb_pkg::qlb_adv_t         adv,
	input  logic [FRAC_BITS:0]        t,
	input  logic [1:0]                k,
	input  logic                      order,
	output logic signed [FRAC_BITS+1:0] f,
	output logic signed [FRAC_BITS+3:0] d
);

	localparam int OW = FRAC_BITS + 2;
	localparam int PW = 2 * OW;
	localparam int FW = FRAC_BITS + 2;
	localparam int DW = FRAC_BITS + 4;
	localparam int XW = FRAC_BITS + 5;
	localparam logic signed [XW-1:0] ONE_X  = XW'(1) << FRAC_BITS;
	localparam logic signed [FW-1:0] ONE_F  = FW'(1) << FRAC_BITS;
	localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);

	logic signed [XW-1:0] t_x, m1, m2, m3, d_x;
	logic signed [OW-1:0] a_op, b_op;
	logic signed [PW-1:0] prod, prod_r, rnd;
	logic signed [FW-1:0] t_f, f_next;

	logic signed [PW-1:0] prod_s2;
	logic signed [DW-1:0] d_s2;
	logic [FRAC_BITS:0]   t_s2;
	logic [1:0]           k_s2;
	logic                 ord_s2;
	logic signed [FW-1:0] f_s3;
	logic signed [DW-1:0] d_s3;

	always_comb begin
		t_x  = signed'(XW'(t));
		m1   = ONE_X - t_x;
		m2   = ONE_X - (t_x <<< 1);
		m3   = (t_x <<< 1) - ONE_X;
		a_op = (k == qlb_pkg::FACT_0) ? m1[OW-1:0] : t_x[OW-1:0];
		case (k)
			qlb_pkg::FACT_0: b_op = m2[OW-1:0];
			qlb_pkg::FACT_1: b_op = m1[OW-1:0];
			default:         b_op = m3[OW-1:0];
		endcase
		prod = a_op * b_op;
		if (order == qlb_pkg::ORDER_Q1) begin
			d_x = (k == qlb_pkg::FACT_0) ? -ONE_X : ONE_X;
		end else begin
			case (k)
				qlb_pkg::FACT_0: d_x = (t_x <<< 2) - ONE_X - (ONE_X <<< 1);
				qlb_pkg::FACT_1: d_x = (ONE_X <<< 2) - (t_x <<< 3);
				default:         d_x = (t_x <<< 2) - ONE_X;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prod_s2 <= prod;
			d_s2    <= d_x[DW-1:0];
			t_s2    <= t;
			k_s2    <= k;
			ord_s2  <= order;
		end
	end

	always_comb begin
		prod_r = (k_s2 == qlb_pkg::FACT_1) ? (prod_s2 <<< 2) : prod_s2;
		rnd    = (prod_r + HALF_P) >>> FRAC_BITS;
		t_f    = signed'(FW'(t_s2));
		if (ord_s2 == qlb_pkg::ORDER_Q1) begin
			f_next = (k_s2 == qlb_pkg::FACT_0) ? (ONE_F - t_f) : t_f;
		end else begin
			f_next = rnd[FW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			f_s3 <= f_next;
			d_s3 <= d_s2;
		end
	end

	assign f = f_s3;
	assign d = d_s3;

endmodule

// ===== rtl/core/quad_lagrange_basis_eval_core.sv =====
`timescale 1ns / 1ps

// Q1/Q2 Lagrange quad shape function with both partial derivatives.
// Input channel s_*: one item per evaluation point. s_tuser is the order
// (0 bilinear, 1 biquadratic); s_tdata holds node_index, coord_u, coord_v.
// Coordinates above one saturate to one.
// Output channel m_*: one item per input item, in order. m_tdata holds
// shape_value, grad_u, grad_v; m_tuser flags a node index invalid for the
// order, with all data fields zero.
// Throughput: one item per cycle while m_tready does not stall the output.
// Stages: input register, factor multiply, factor round, product
// multiply, output round, with at most one multiplier level per stage.
// A stall on m_tready holds the output and lets earlier stages fill their
// bubbles; s_tready drops only when every stage holds an item.
// Reset clears all valid bits; the block takes an item in the first cycle
// after arst_n is released.
module quad_lagrange_basis_eval_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// node_index[3:0], coord_u, coord_v, zero pad
	input  logic [((2*FRAC_BITS+6+7)/8)*8-1:0] s_tdata,
	// func
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// shape_value, grad_u, grad_v, zero pad
	output logic [((3*FRAC_BITS+13+7)/8)*8-1:0] m_tdata,
	// bad_index
	output logic m_tuser
);

	localparam int CW    = FRAC_BITS + 1;
	localparam int VW    = FRAC_BITS + 3;
	localparam int GW    = FRAC_BITS + 5;
	localparam int FW    = FRAC_BITS + 2;
	localparam int DW    = FRAC_BITS + 4;
	localparam int NW    = 4;
	localparam int PVW   = 2 * FW;
	localparam int PGW   = FW + DW;
	localparam int OUT_W = ((3*FRAC_BITS+13+7)/8)*8;
	localparam logic [CW-1:0]         ONE_C  = CW'(1) << FRAC_BITS;
	localparam logic signed [PVW-1:0] HALF_V = PVW'(1) << (FRAC_BITS - 1);
	localparam logic signed [PGW-1:0] HALF_G = PGW'(1) << (FRAC_BITS - 1);

	logic adv1, adv2, adv3, adv4, adv5;
	qlb_pkg::qlb_adv_t adv;
	qlb_pkg::qlb_node_t dec;

	logic [NW-1:0] node_in;
	logic [CW-1:0] u_raw, v_raw, u_sat, v_sat;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [CW-1:0] u_s1, v_s1;
	logic [1:0]    iu_s1, iv_s1;
	logic          ord_s1, bad_s1, bad_s2, bad_s3, bad_s4, bad_s5;

	logic signed [FW-1:0] f_u, f_v;
	logic signed [DW-1:0] d_u, d_v;

	logic signed [PVW-1:0] pv_s4, rv;
	logic signed [PGW-1:0] pu_s4, pw_s4, ru, rw;
	logic [VW-1:0] val_s5;
	logic [GW-1:0] gu_s5, gv_s5;

	assign adv5     = !vld_s5 || m_tready;
	assign adv4     = !vld_s4 || adv5;
	assign adv3     = !vld_s3 || adv4;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign s_tready = adv1;
	assign adv.s2   = adv2;
	assign adv.s3   = adv3;

	assign node_in = s_tdata[NW-1:0];
	assign u_raw   = s_tdata[NW +: CW];
	assign v_raw   = s_tdata[NW+CW +: CW];
	assign u_sat   = (u_raw > ONE_C) ? ONE_C : u_raw;
	assign v_sat   = (v_raw > ONE_C) ? ONE_C : v_raw;
	assign dec     = qlb_pkg::node_decode(s_tuser, node_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= s_tvalid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			u_s1   <= u_sat;
			v_s1   <= v_sat;
			iu_s1  <= dec.iu;
			iv_s1  <= dec.iv;
			ord_s1 <= s_tuser;
			bad_s1 <= dec.bad;
		end
		if (adv2) bad_s2 <= bad_s1;
		if (adv3) bad_s3 <= bad_s2;
	end

	qlb_factor #(.FRAC_BITS(FRAC_BITS)) u_fac_u (
		.clk   (clk),
		.adv   (adv),
		.t     (u_s1),
		.k     (iu_s1),
		.order (ord_s1),
		.f     (f_u),
		.d     (d_u)
	);

	qlb_factor #(.FRAC_BITS(FRAC_BITS)) u_fac_v (
		.clk   (clk),
		.adv   (adv),
		.t     (v_s1),
		.k     (iv_s1),
		.order (ord_s1),
		.f     (f_v),
		.d     (d_v)
	);

	always_ff @(posedge clk) begin
		if (adv4) begin
			pv_s4  <= f_u * f_v;
			pu_s4  <= d_u * f_v;
			pw_s4  <= f_u * d_v;
			bad_s4 <= bad_s3;
		end
	end

	assign rv = (pv_s4 + HALF_V) >>> FRAC_BITS;
	assign ru = (pu_s4 + HALF_G) >>> FRAC_BITS;
	assign rw = (pw_s4 + HALF_G) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (adv5) begin
			val_s5 <= bad_s4 ? '0 : rv[VW-1:0];
			gu_s5  <= bad_s4 ? '0 : ru[GW-1:0];
			gv_s5  <= bad_s4 ? '0 : rw[GW-1:0];
			bad_s5 <= bad_s4;
		end
	end

	assign m_tvalid = vld_s5;
	assign m_tdata  = OUT_W'({gv_s5, gu_s5, val_s5});
	assign m_tuser  = bad_s5;

endmodule

// ===== rtl/core/qlb_checker.sv =====
`timescale 1ns / 1ps
`include "quad_lagrange_basis_eval_core_defines.svh"

module qlb_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [((2*FRAC_BITS+6+7)/8)*8-1:0] s_tdata,
	input logic s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((3*FRAC_BITS+13+7)/8)*8-1:0] m_tdata,
	input logic m_tuser
);

	// flagged node carries all-zero data
	`QLB_ASSERT(a_bad_zero, m_tvalid && m_tuser |-> m_tdata == '0, "bad index with data")

	// an empty or draining output stage always lets the input side move
	`QLB_ASSERT(a_ready_free, !m_tvalid || m_tready |-> s_tready, "input blocked needlessly")

	// stalled result holds
	`QLB_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled item changed")

endmodule

bind quad_lagrange_basis_eval_core qlb_checker #(.FRAC_BITS(FRAC_BITS)) u_qlb_checker (.*);
